[rtl/ipd_pkg.sv]
// Package for the 3x3 isolated pixel detector: widths, register indexes, command codes,
// request structs and the per-item step record shared by all modules.
// No dependencies.
package ipd_pkg;

  localparam int unsigned DIM_W         = 11;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned PIXEL_BITS    = 24;
  localparam int unsigned TOL_W         = 24;
  localparam int unsigned CMP_W         = (PIXEL_BITS > TOL_W) ? PIXEL_BITS : TOL_W;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [TOL_W-1:0] TOLERANCE_RST    = 24'd0;

  typedef struct packed {
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel;
  } in_req_t;

  typedef struct packed {
    logic                  decided;
    logic                  isolated;
    logic [DIM_W-1:0]      column;
    logic [DIM_W-1:0]      row;
    logic [PIXEL_BITS-1:0] colour;
  } out_req_t;

  typedef struct packed {
    logic             act;
    logic             have;
    logic             drain;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic [DIM_W-1:0] column;
    logic [DIM_W-1:0] row;
  } step_t;

endpackage

[rtl/isolated_pixel_detector_3x3.sv]
// Top level of the 3x3 isolated pixel detector.
// Depends on ipd_pkg, ipd_ctrl, ipd_line_store and ipd_window.
//
// Usage: frames of pixels enter in raster order on the in channel
// (in_valid_i / in_stall_o, payload in_req_i). After the last pixel of a
// frame the source sends frame_width+1 requests of either command to drain
// the remaining decisions; the block then starts the next frame.
// Every accepted request yields exactly one result on the out channel
// (out_valid_o / out_stall_i, payload out_req_o); decided marks results
// that carry a pixel decision, all other fields are zero otherwise.
// A request passes the middle stage and the output register before its
// result appears. Throughput: one request per cycle unless out_stall_i
// holds; the line memories take one read and one write per cycle and
// the window is judged in a single stage.
// When out_stall_i holds, one more request is taken into the middle stage,
// then in_stall_o rises until the output register is emptied.
// Configuration (frame width, frame height, tolerance) is written through
// the cfg channel, which is always ready; write it only while idle.
// Reset clears counters, window and pipeline; no clearing pass is needed.
module isolated_pixel_detector_3x3 #(
  parameter int unsigned MAX_WIDTH = ipd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ipd_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ipd_pkg::out_req_t              out_req_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = ipd_pkg::DIM_W;
  localparam int unsigned PB = ipd_pkg::PIXEL_BITS;
  localparam int unsigned TW = ipd_pkg::TOL_W;

  logic [DW-1:0] width_q, width_d, height_q, height_d;
  logic [TW-1:0] tol_q, tol_d;

  logic                accept, o_load, b_move, wr_en;
  logic [AW-1:0]       a_addr;
  ipd_pkg::step_t      a_step;

  logic                b_valid_q;
  ipd_pkg::step_t      b_step_q;
  logic [AW-1:0]       b_addr_q;
  logic [PB-1:0]       b_px_q;

  logic [PB-1:0]       up, mid, centre;
  logic                isolated;

  logic                o_valid_q;
  ipd_pkg::out_req_t   o_req_q, o_req_d;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    tol_d    = tol_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ipd_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i[DW-1:0];
        ipd_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i[DW-1:0];
        ipd_pkg::REG_TOLERANCE:    tol_d    = cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ipd_pkg::FRAME_WIDTH_RST;
      height_q <= ipd_pkg::FRAME_HEIGHT_RST;
      tol_q    <= ipd_pkg::TOLERANCE_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      tol_q    <= tol_d;
    end
  end

  // handshake
  assign o_load     = !o_valid_q || !out_stall_i;
  assign b_move     = b_valid_q && o_load;
  assign in_stall_o = b_valid_q && !o_load;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = b_move && b_step_q.act;

  ipd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (in_req_i.command),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .addr_o         (a_addr),
    .step_o         (a_step)
  );

  ipd_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (a_addr),
    .wr_en_i     (wr_en),
    .wr_addr_i   (b_addr_q),
    .wr_upper_i  (mid),
    .wr_middle_i (b_px_q),
    .upper_o     (up),
    .middle_o    (mid)
  );

  // middle stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (accept) begin
      b_valid_q <= 1'b1;
    end else if (b_move) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_step_q <= a_step;
      b_addr_q <= a_addr;
      b_px_q   <= a_step.drain ? '0 : in_req_i.pixel;
    end
  end

  ipd_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (wr_en),
    .upper_i     (up),
    .middle_i    (mid),
    .bottom_i    (b_px_q),
    .step_i      (b_step_q),
    .tolerance_i (tol_q),
    .isolated_o  (isolated),
    .centre_o    (centre)
  );

  // output register
  always_comb begin
    o_req_d = '0;
    if (b_step_q.have) begin
      o_req_d.decided  = 1'b1;
      o_req_d.isolated = isolated;
      o_req_d.column   = b_step_q.column;
      o_req_d.row      = b_step_q.row;
      o_req_d.colour   = centre;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (b_move) begin
      o_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      o_req_q <= o_req_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_req_o   = o_req_q;

endmodule

[rtl/ipd_ctrl.sv]
// Position counters and decision bookkeeping for the isolated pixel detector.
// Produces the line store address and the step record of each accepted request.
// Depends on ipd_pkg.
module ipd_ctrl #(
  parameter int unsigned MAX_WIDTH = ipd_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            cmd_i,
  input  logic [ipd_pkg::DIM_W-1:0]       frame_width_i,
  input  logic [ipd_pkg::DIM_W-1:0]       frame_height_i,
  output logic [$clog2(MAX_WIDTH)-1:0]    addr_o,
  output ipd_pkg::step_t                  step_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW = ipd_pkg::DIM_W;
  localparam int unsigned XW = (CW > DW) ? CW : DW;
  localparam int unsigned RW = ipd_pkg::ROW_W;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [DW-1:0] fc_q, fc_d;

  logic [XW-1:0] fw_x, w, nc;
  logic [XW:0]   w_inc;
  logic [DW-1:0] h, fc_inc;
  logic [AW-1:0] ic, dc;
  logic [RW-1:0] ir, dr;
  logic          wrap, drain, ignore, col_end, have0;

  always_comb begin
    fw_x = XW'(frame_width_i);
    if (frame_width_i == '0) begin
      w = XW'(1);
    end else if (fw_x > XW'(MAX_WIDTH)) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = fw_x;
    end
    h = (frame_height_i == '0) ? DW'(1) : frame_height_i;

    // column left beyond a narrowed width wraps to the next row
    wrap    = XW'(col_q) >= w;
    ic      = wrap ? '0 : col_q;
    ir      = wrap ? row_q + RW'(1) : row_q;
    drain   = ir >= RW'(h);
    ignore  = (cmd_i == ipd_pkg::CMD_FLUSH) && !drain;
    nc      = XW'(ic) + XW'(1);
    col_end = nc >= w;
    fc_inc  = fc_q + DW'(1);
    w_inc   = {1'b0, w} + (XW+1)'(1);

    col_d = col_q;
    row_d = row_q;
    fc_d  = fc_q;
    if (accept_i) begin
      if (ignore) begin
        col_d = ic;
        row_d = ir;
      end else begin
        col_d = col_end ? '0 : AW'(nc);
        row_d = col_end ? ir + RW'(1) : ir;
        if (drain) begin
          if ((XW+1)'(fc_inc) >= w_inc) begin
            col_d = '0;
            row_d = '0;
            fc_d  = '0;
          end else begin
            fc_d = fc_inc;
          end
        end
      end
    end

    // column 0 closes out the last pixel of the row two above
    if (ic != '0) begin
      have0 = ir >= RW'(1);
      dr    = ir - RW'(1);
      dc    = ic - AW'(1);
    end else begin
      have0 = ir >= RW'(2);
      dr    = ir - RW'(2);
      dc    = AW'(w - XW'(1));
    end

    addr_o          = ic;
    step_o.act      = !ignore;
    step_o.drain    = drain;
    step_o.have     = !ignore && have0 && (dr < RW'(h));
    step_o.top_ok   = dr != '0;
    step_o.bot_ok   = ({1'b0, dr} + (RW+1)'(1)) < (RW+1)'(h);
    step_o.left_ok  = dc != '0;
    step_o.right_ok = (XW'(dc) + XW'(1)) < w;
    step_o.column   = DW'(XW'(dc) + XW'(1));
    step_o.row      = DW'(dr + RW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      fc_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      fc_q  <= fc_d;
    end
  end

endmodule

[rtl/ipd_line_store.sv]
// Two line memories holding the rows two and one above the input row.
// Registered reads with bypass of a write landing at the same edge.
// Depends on ipd_pkg.
module ipd_line_store #(
  parameter int unsigned MAX_WIDTH = ipd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]      wr_addr_i,
  input  logic [ipd_pkg::PIXEL_BITS-1:0]    wr_upper_i,
  input  logic [ipd_pkg::PIXEL_BITS-1:0]    wr_middle_i,
  output logic [ipd_pkg::PIXEL_BITS-1:0]    upper_o,
  output logic [ipd_pkg::PIXEL_BITS-1:0]    middle_o
);

  localparam int unsigned PB = ipd_pkg::PIXEL_BITS;

  logic [PB-1:0] upper_mem  [MAX_WIDTH];
  logic [PB-1:0] middle_mem [MAX_WIDTH];

  logic [PB-1:0] rd_upper_q, rd_middle_q;
  logic [PB-1:0] fwd_upper_q, fwd_middle_q;
  logic          fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
    if (rd_en_i) begin
      rd_upper_q  <= upper_mem[rd_addr_i];
      rd_middle_q <= middle_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_upper_q  <= wr_upper_i;
      fwd_middle_q <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign upper_o  = fwd_q ? fwd_upper_q  : rd_upper_q;
  assign middle_o = fwd_q ? fwd_middle_q : rd_middle_q;

endmodule

[rtl/ipd_window.sv]
// 3x3 pixel window and the eight neighbor comparisons against tolerance.
// Judges the window as it stands after the current shift.
// Depends on ipd_pkg.
module ipd_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic [ipd_pkg::PIXEL_BITS-1:0] upper_i,
  input  logic [ipd_pkg::PIXEL_BITS-1:0] middle_i,
  input  logic [ipd_pkg::PIXEL_BITS-1:0] bottom_i,
  input  ipd_pkg::step_t                 step_i,
  input  logic [ipd_pkg::TOL_W-1:0]      tolerance_i,
  output logic                           isolated_o,
  output logic [ipd_pkg::PIXEL_BITS-1:0] centre_o
);

  localparam int unsigned PB = ipd_pkg::PIXEL_BITS;
  localparam int unsigned CMPW = ipd_pkg::CMP_W;

  // index col*3+row, col 0 is leftmost
  logic [PB-1:0] win_q [9];
  logic [PB-1:0] view  [9];

  always_comb begin
    logic            inside_ok;
    logic [CMPW-1:0] a, b, diff;
    for (int k = 0; k < 6; k++) begin
      view[k] = win_q[k+3];
    end
    view[6] = upper_i;
    view[7] = middle_i;
    view[8] = bottom_i;

    isolated_o = 1'b1;
    a = CMPW'(view[4]);
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        inside_ok = !(dx == 1 && dy == 1) &&
                    (dx != 0 || step_i.left_ok) && (dx != 2 || step_i.right_ok) &&
                    (dy != 0 || step_i.top_ok) && (dy != 2 || step_i.bot_ok);
        b    = CMPW'(view[dx*3+dy]);
        diff = (a > b) ? a - b : b - a;
        if (inside_ok && !(diff > CMPW'(tolerance_i))) begin
          isolated_o = 1'b0;
        end
      end
    end
    centre_o = view[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= view[k];
      end
    end
  end

endmodule

[rtl/ipd_checker.sv]
// Port-level assertions for the isolated pixel detector, bound to the top.
// Depends on ipd_pkg and isolated_pixel_detector_3x3.
module ipd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ipd_pkg::out_req_t out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("stalled result changed");

  a_undecided_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.decided |->
      (out_req_o.isolated == 1'b0) && (out_req_o.column == '0) &&
      (out_req_o.row == '0) && (out_req_o.colour == '0))
    else $error("undecided result carries data");

  a_decided_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.decided |->
      (out_req_o.column != '0) && (out_req_o.row != '0))
    else $error("decided result without position");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind isolated_pixel_detector_3x3 ipd_checker u_ipd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

[verif/isolated_pixel_detector_3x3_tb.sv]
`timescale 1ns / 100ps
// Testbench for isolated_pixel_detector_3x3: streams pixel frames with random idling
// on both channels and checks every result against an in-bench window predictor.
// Depends on ipd_pkg and the detector RTL.
module isolated_pixel_detector_3x3_tb;

  localparam int unsigned LINE_MAX    = 1024;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned ITEM_TARGET = 1650;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  ipd_pkg::in_req_t               in_req    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ipd_pkg::out_req_t              out_req;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ipd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ipd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state
  logic [ipd_pkg::PIXEL_BITS-1:0] upper_row [LINE_MAX];
  logic [ipd_pkg::PIXEL_BITS-1:0] middle_row [LINE_MAX];
  logic [ipd_pkg::PIXEL_BITS-1:0] win_px [9];
  int unsigned                    col_pos, row_pos, drain_cnt;
  logic [ipd_pkg::DIM_W-1:0]      width_reg;
  logic [ipd_pkg::DIM_W-1:0]      height_reg;
  logic [ipd_pkg::TOL_W-1:0]      tol_reg;

  ipd_pkg::in_req_t  pending_px [$];
  ipd_pkg::out_req_t decisions_q [$];
  bit                in_took      = 1'b0;
  bit                calm         = 1'b0;
  bit                smooth       = 1'b0;
  int unsigned       in_gap       = 0;
  int unsigned       stall_left   = 0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       random_items = 0;

  isolated_pixel_detector_3x3 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [ipd_pkg::PIXEL_BITS-1:0] rand_px();
    return ipd_pkg::PIXEL_BITS'($urandom);
  endfunction

  function automatic ipd_pkg::out_req_t decide_pixel(ipd_pkg::in_req_t req);
    ipd_pkg::out_req_t              res;
    int unsigned                    w, h, ic, ir, dr, dc;
    logic [ipd_pkg::PIXEL_BITS-1:0] px, up, mid, diff, nb;
    logic [ipd_pkg::PIXEL_BITS-1:0] view [9];
    bit                             have, in_frame, top_ok, bot_ok, left_ok, right_ok;
    res  = '0;
    have = 1'b0;
    dr   = 0;
    dc   = 0;
    w    = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
    h    = (height_reg == 0) ? 1 : height_reg;
    px   = req.pixel;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 12'hFFF;
    end
    ic = col_pos;
    ir = row_pos;
    if (req.command == ipd_pkg::CMD_FLUSH && ir < h) return res;
    if (ir >= h) px = '0;
    up  = upper_row[ic];
    mid = middle_row[ic];
    // column 0 closes the row two above: judge from the window after the shift
    if (ic == 0) begin
      if (ir >= 2) begin
        have = 1'b1;
        dr   = ir - 2;
        dc   = w - 1;
      end
      for (int k = 0; k < 6; k++) view[k] = win_px[k + 3];
      view[6] = up;
      view[7] = mid;
      view[8] = px;
    end
    for (int k = 0; k < 6; k++) win_px[k] = win_px[k + 3];
    win_px[6] = up;
    win_px[7] = mid;
    win_px[8] = px;
    if (ic != 0) begin
      if (ir >= 1) begin
        have = 1'b1;
        dr   = ir - 1;
        dc   = ic - 1;
      end
      for (int k = 0; k < 9; k++) view[k] = win_px[k];
    end
    if (have && (dr >= h || dc >= w)) have = 1'b0;
    if (have) begin
      top_ok       = dr >= 1;
      bot_ok       = dr + 1 < h;
      left_ok      = dc >= 1;
      right_ok     = dc + 1 < w;
      res.decided  = 1'b1;
      res.isolated = 1'b1;
      for (int dx = 0; dx < 3; dx++) begin
        for (int dy = 0; dy < 3; dy++) begin
          in_frame = !(dx == 1 && dy == 1) && (dx != 0 || left_ok) && (dx != 2 || right_ok) &&
                     (dy != 0 || top_ok) && (dy != 2 || bot_ok);
          nb       = view[dx * 3 + dy];
          diff     = (view[4] > nb) ? view[4] - nb : nb - view[4];
          if (in_frame && diff <= tol_reg) res.isolated = 1'b0;
        end
      end
      res.column = ipd_pkg::DIM_W'(dc + 1);
      res.row    = ipd_pkg::DIM_W'(dr + 1);
      res.colour = view[4];
    end
    upper_row[ic]  = mid;
    middle_row[ic] = px;
    col_pos = ic + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (ir + 1) & 12'hFFF;
    end
    if (ir >= h) begin
      drain_cnt = (drain_cnt + 1) & 11'h7FF;
      if (drain_cnt >= w + 1) begin
        col_pos   = 0;
        row_pos   = 0;
        drain_cnt = 0;
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, ipd_pkg::out_req_t want, ipd_pkg::out_req_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%0t %s: expected d=%0b iso=%0b col=%0d row=%0d colour=%06h", $realtime, what,
               want.decided, want.isolated, want.column, want.row, want.colour);
      $display("    actual d=%0b iso=%0b col=%0d row=%0d colour=%06h",
               got.decided, got.isolated, got.column, got.row, got.colour);
    end
  endtask

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    ipd_pkg::out_req_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decisions_q.size() == 0) begin
          note_mismatch("result with nothing pending", '0, out_req);
        end else begin
          want = decisions_q.pop_front();
          if (out_req.decided !== want.decided || out_req.isolated !== want.isolated ||
              out_req.column !== want.column || out_req.row !== want.row ||
              out_req.colour !== want.colour)
            note_mismatch("result mismatch", want, out_req);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        decisions_q.push_back(decide_pixel(in_req));
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (in_gap != 0) begin
        in_gap   = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_px.size() != 0) begin
        in_req   <= pending_px.pop_front();
        in_valid <= 1'b1;
        if (!calm && !smooth && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && !smooth && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
    end
  end

  task automatic push_item(logic cmd, logic [ipd_pkg::PIXEL_BITS-1:0] px);
    ipd_pkg::in_req_t r;
    r.command = cmd;
    r.pixel   = px;
    pending_px.push_back(r);
  endtask

  task automatic set_regs(int unsigned w, int unsigned h, logic [ipd_pkg::TOL_W-1:0] tol);
    logic [ipd_pkg::CFG_IDX_W-1:0]  idx [3];
    logic [ipd_pkg::CFG_DATA_W-1:0] val [3];
    idx[0] = ipd_pkg::REG_FRAME_WIDTH;
    idx[1] = ipd_pkg::REG_FRAME_HEIGHT;
    idx[2] = ipd_pkg::REG_TOLERANCE;
    val[0] = ipd_pkg::CFG_DATA_W'(w);
    val[1] = ipd_pkg::CFG_DATA_W'(h);
    val[2] = tol;
    for (int k = 0; k < 3; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx[k])
        ipd_pkg::REG_FRAME_WIDTH:  width_reg  = val[k][ipd_pkg::DIM_W-1:0];
        ipd_pkg::REG_FRAME_HEIGHT: height_reg = val[k][ipd_pkg::DIM_W-1:0];
        ipd_pkg::REG_TOLERANCE:    tol_reg    = val[k][ipd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_px.size() != 0 || in_valid || decisions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one frame plus its drain; noise adds ignored flushes, drained pixels, extra flushes
  task automatic push_frame(int unsigned w, int unsigned h, bit counted);
    logic [ipd_pkg::PIXEL_BITS-1:0] base;
    bit                             flat;
    flat = $urandom_range(0, 2) != 0;
    base = rand_px();
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 39) == 0) push_item(ipd_pkg::CMD_FLUSH, rand_px());
      if (!flat || $urandom_range(0, 5) == 0) push_item(ipd_pkg::CMD_PIXEL, rand_px());
      else push_item(ipd_pkg::CMD_PIXEL,
                     base + ipd_pkg::PIXEL_BITS'($urandom_range(0, 7)));
    end
    for (int unsigned i = 0; i <= w; i++)
      push_item(($urandom_range(0, 7) == 0) ? ipd_pkg::CMD_PIXEL : ipd_pkg::CMD_FLUSH,
                rand_px());
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) push_item(ipd_pkg::CMD_FLUSH, rand_px());
    if (counted) random_items += w * h + w + 1;
  endtask

  task automatic run_phase(int unsigned w_reg, int unsigned h_reg,
                           logic [ipd_pkg::TOL_W-1:0] tol, int unsigned frames, bit counted);
    int unsigned ew, eh;
    set_regs(w_reg, h_reg, tol);
    ew     = (w_reg == 0) ? 1 : ((w_reg > LINE_MAX) ? LINE_MAX : w_reg);
    eh     = (h_reg == 0) ? 1 : h_reg;
    smooth = $urandom_range(0, 3) == 0;
    repeat (frames) push_frame(ew, eh, counted);
    wait_idle();
  endtask

  initial begin
    int unsigned               w_reg, h_reg;
    logic [ipd_pkg::TOL_W-1:0] tol;
    width_reg  = ipd_pkg::FRAME_WIDTH_RST;
    height_reg = ipd_pkg::FRAME_HEIGHT_RST;
    tol_reg    = ipd_pkg::TOLERANCE_RST;
    col_pos    = 0;
    row_pos    = 0;
    drain_cnt  = 0;
    for (int k = 0; k < LINE_MAX; k++) begin
      upper_row[k]  = '0;
      middle_row[k] = '0;
    end
    for (int k = 0; k < 9; k++) win_px[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x2 frame: field extremes, flush mid-frame, pixel while draining, extra flushes
    set_regs(3, 2, '0);
    push_item(ipd_pkg::CMD_PIXEL, 24'h000000);
    push_item(ipd_pkg::CMD_PIXEL, 24'hFFFFFF);
    push_item(ipd_pkg::CMD_FLUSH, 24'h555555);
    push_item(ipd_pkg::CMD_PIXEL, 24'h000000);
    push_item(ipd_pkg::CMD_PIXEL, 24'h000000);
    push_item(ipd_pkg::CMD_PIXEL, 24'h000001);
    push_item(ipd_pkg::CMD_PIXEL, 24'hFFFFFF);
    push_item(ipd_pkg::CMD_FLUSH, 24'h000000);
    push_item(ipd_pkg::CMD_PIXEL, 24'h123456);
    push_item(ipd_pkg::CMD_FLUSH, 24'hFFFFFF);
    push_item(ipd_pkg::CMD_FLUSH, 24'h000000);
    push_item(ipd_pkg::CMD_FLUSH, 24'h000000);
    push_item(ipd_pkg::CMD_FLUSH, 24'hFFFFFF);
    wait_idle();
    // zero width and height act as one
    set_regs(0, 0, 24'hFFFFFF);
    push_item(ipd_pkg::CMD_PIXEL, 24'hABCDEF);
    push_item(ipd_pkg::CMD_FLUSH, 24'h000000);
    push_item(ipd_pkg::CMD_FLUSH, 24'hFFFFFF);
    wait_idle();

    while (random_items < ITEM_TARGET) begin
      if (random_items > ITEM_TARGET - 200) calm = 1'b1;
      w_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
      h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(0, 3))
        0:       tol = '0;
        1:       tol = 24'($urandom_range(0, 15));
        2:       tol = ipd_pkg::TOL_W'($urandom);
        default: tol = 24'hFFFFFF;
      endcase
      run_phase(w_reg, h_reg, tol, $urandom_range(1, 3), 1'b1);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[isolated_pixel_detector_3x3.f]
rtl/ipd_pkg.sv
rtl/ipd_ctrl.sv
rtl/ipd_line_store.sv
rtl/ipd_window.sv
rtl/isolated_pixel_detector_3x3.sv
rtl/ipd_checker.sv
verif/isolated_pixel_detector_3x3_tb.sv
